// ===== hw/rtl/nms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_pkg
// Shared types, constants and arithmetic helpers of the noise shaper.
// ----------------------------------------------------------------------------
package nms_pkg;

  // Random word width; scaled word is floor(2 * R * 2^16 / 2^RANDOM_BITS)
  localparam int RANDOM_BITS = 16;

  localparam int WPOS_W   = 17;   // scaled word, Q16 in 0..2
  localparam int W_W      = 18;   // centred word, signed Q16
  localparam int OUT_W    = 23;   // signed Q6.16 sample
  localparam int ACC_W    = 32;   // pole state, signed Q7.24
  localparam int PROD_W   = 44;   // input coefficient times centred word
  localparam int TERM_W   = 52;   // input term, scaled by 2^8
  localparam int DIRECT_W = 26;   // rounded direct term, signed Q1.24
  localparam int PADDR_W  = 4;

  localparam logic [WPOS_W-1:0] Q_ONE = WPOS_W'(65536);

  localparam logic signed [OUT_W-1:0] OUT_MAX = 23'sd4194303;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -23'sd4194304;

  // Filter coefficients scaled by 2^24: Q0.24 poles, signed Q1.24 input and direct gains
  localparam logic [23:0]        C_SLOW_POLE = 24'd16737790;
  localparam logic signed [25:0] C_SLOW_IN   = 26'sd1661716;
  localparam logic [23:0]        C_MID_POLE  = 24'd16156459;
  localparam logic signed [25:0] C_MID_IN    = 26'sd4974720;
  localparam logic [23:0]        C_FAST_POLE = 24'd9563013;
  localparam logic signed [25:0] C_FAST_IN   = 26'sd17661229;
  localparam logic signed [25:0] C_DIRECT    = 26'sd3100430;

  // Register reset values
  localparam logic [18:0] HOLD_PERIOD_RST     = 19'd25100;
  localparam logic [16:0] OUT_LEVEL_RST       = 17'd32768;
  localparam logic [17:0] PULSE_THRESHOLD_RST = 18'd65536;

  typedef enum logic [1:0] {
    MODE_WHITE = 2'd0,
    MODE_HOLD  = 2'd1,
    MODE_PINK  = 2'd2,
    MODE_PULSE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE            = 2'd0,
    REG_HOLD_PERIOD     = 2'd1,
    REG_OUT_LEVEL       = 2'd2,
    REG_PULSE_THRESHOLD = 2'd3
  } reg_idx_t;

  typedef struct packed {
    mode_t       mode;
    logic [18:0] hold_period;
    logic [16:0] out_level;
    logic [17:0] pulse_threshold;
  } cfg_t;

  // Precomputed per-item values handed from the front end to the core
  typedef struct packed {
    logic signed [OUT_W-1:0]    w_val;
    logic signed [OUT_W-1:0]    hold_val;
    logic signed [OUT_W-1:0]    pulse_val;
    logic signed [TERM_W-1:0]   slow_term;
    logic signed [TERM_W-1:0]   mid_term;
    logic signed [TERM_W-1:0]   fast_term;
    logic signed [DIRECT_W-1:0] direct;
  } item_t;

  // b * w * 2^8
  function automatic logic signed [TERM_W-1:0] in_term(
    input logic signed [25:0]    coef,
    input logic signed [W_W-1:0] w
  );
    logic signed [PROD_W-1:0] p;
    p = coef * w;
    return {p, 8'b0};
  endfunction

  // acc' = sat32(round((a * acc + term) / 2^24))
  function automatic logic signed [ACC_W-1:0] pole_step(
    input logic signed [ACC_W-1:0]  acc,
    input logic [23:0]              a,
    input logic signed [TERM_W-1:0] term
  );
    logic signed [56:0] prod;
    logic signed [58:0] v;
    logic signed [34:0] q;
    prod = $signed({1'b0, a}) * acc;
    v = 59'(prod) + 59'(term) + 59'sd8388608;
    q = v[58:24];
    if (q > 35'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (q < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [27:0] v);
    if (v > 28'(OUT_MAX)) begin
      return OUT_MAX;
    end else if (v < 28'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/nms_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module nms_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nms_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output nms_pkg::cfg_t                cfg
);

  nms_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = nms_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode            <= nms_pkg::MODE_WHITE;
      cfg.hold_period     <= nms_pkg::HOLD_PERIOD_RST;
      cfg.out_level       <= nms_pkg::OUT_LEVEL_RST;
      cfg.pulse_threshold <= nms_pkg::PULSE_THRESHOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        nms_pkg::REG_MODE:            cfg.mode <= nms_pkg::mode_t'(pwdata[1:0]);
        nms_pkg::REG_HOLD_PERIOD:     cfg.hold_period <= pwdata[18:0];
        nms_pkg::REG_OUT_LEVEL:       cfg.out_level <= pwdata[16:0];
        nms_pkg::REG_PULSE_THRESHOLD: cfg.pulse_threshold <= pwdata[17:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      nms_pkg::REG_MODE:            prdata = {30'b0, cfg.mode};
      nms_pkg::REG_HOLD_PERIOD:     prdata = {13'b0, cfg.hold_period};
      nms_pkg::REG_OUT_LEVEL:       prdata = {15'b0, cfg.out_level};
      nms_pkg::REG_PULSE_THRESHOLD: prdata = {14'b0, cfg.pulse_threshold};
    endcase
  end

endmodule

// ===== hw/rtl/nms_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_front
// Input register and product stage: scales the random word and forms every
// term that does not depend on filter or hold state.
// ----------------------------------------------------------------------------
module nms_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nms_pkg::RANDOM_BITS-1:0]   random_word,
  input  nms_pkg::cfg_t                     cfg,
  output logic                              b_valid,
  output nms_pkg::item_t                    b_item,
  input  logic                              c_free
);

  logic                                 a_valid;
  logic [nms_pkg::RANDOM_BITS-1:0]      a_word;
  logic                                 a_free;
  logic                                 b_free;

  logic [nms_pkg::RANDOM_BITS+16:0]     ext;
  logic [nms_pkg::WPOS_W-1:0]           wpos;
  logic signed [nms_pkg::W_W-1:0]       w;
  logic [33:0]                          lvl_prod;
  logic signed [19:0]                   hold_cand;
  logic signed [nms_pkg::PROD_W-1:0]    dir_prod;
  logic signed [nms_pkg::TERM_W-1:0]    dir_term;
  logic signed [nms_pkg::TERM_W-1:0]    dir_round;
  logic signed [nms_pkg::OUT_W-1:0]     level_s;
  nms_pkg::item_t                       b_item_next;

  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign in_stall = !a_free;

  always_comb begin
    ext       = {a_word, 17'b0};
    wpos      = nms_pkg::WPOS_W'(ext >> nms_pkg::RANDOM_BITS);
    w         = $signed({1'b0, wpos}) - $signed({1'b0, nms_pkg::Q_ONE});
    lvl_prod  = cfg.out_level * wpos;
    hold_cand = $signed({2'b0, lvl_prod[33:16]}) - 20'sd65536;
    dir_prod  = nms_pkg::C_DIRECT * w;
    dir_term  = {dir_prod, 8'b0};
    dir_round = dir_term + 52'sd8388608;
    level_s   = $signed({6'b0, cfg.out_level});

    b_item_next.w_val     = nms_pkg::OUT_W'(w);
    b_item_next.hold_val  = nms_pkg::OUT_W'(hold_cand);
    b_item_next.pulse_val = ({1'b0, wpos} > cfg.pulse_threshold) ? level_s : -level_s;
    b_item_next.slow_term = nms_pkg::in_term(nms_pkg::C_SLOW_IN, w);
    b_item_next.mid_term  = nms_pkg::in_term(nms_pkg::C_MID_IN, w);
    b_item_next.fast_term = nms_pkg::in_term(nms_pkg::C_FAST_IN, w);
    b_item_next.direct    = dir_round[49:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= in_valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
    end
    if (a_free && in_valid) begin
      a_word <= random_word;
    end
    if (b_free && a_valid) begin
      b_item <= b_item_next;
    end
  end

endmodule

// ===== hw/rtl/nms_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_core
// State stage (hold counter, held value, three filter poles) followed by the
// output register that forms the final sample.
// ----------------------------------------------------------------------------
module nms_core (
  input  logic                          clk,
  input  logic                          rst,
  input  nms_pkg::cfg_t                 cfg,
  input  logic                          b_valid,
  input  nms_pkg::item_t                b_item,
  output logic                          c_free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [nms_pkg::OUT_W-1:0] sample_out
);

  logic                                  c_valid;
  logic                                  c_pink;
  logic signed [nms_pkg::OUT_W-1:0]      c_y;
  logic signed [nms_pkg::DIRECT_W-1:0]   c_direct;
  logic                                  d_free;
  logic                                  take_c;

  logic [18:0]                           hold_counter;
  logic [18:0]                           hold_counter_next;
  logic signed [nms_pkg::OUT_W-1:0]      held_value;
  logic signed [nms_pkg::OUT_W-1:0]      held_value_next;
  logic signed [nms_pkg::ACC_W-1:0]      pink_slow_acc;
  logic signed [nms_pkg::ACC_W-1:0]      pink_mid_acc;
  logic signed [nms_pkg::ACC_W-1:0]      pink_fast_acc;
  logic signed [nms_pkg::ACC_W-1:0]      pink_slow_acc_next;
  logic signed [nms_pkg::ACC_W-1:0]      pink_mid_acc_next;
  logic signed [nms_pkg::ACC_W-1:0]      pink_fast_acc_next;
  logic [18:0]                           cnt_inc;
  logic signed [nms_pkg::OUT_W-1:0]      c_y_next;
  logic signed [35:0]                    pink_sum;
  logic signed [nms_pkg::OUT_W-1:0]      pink_y;

  assign d_free = !out_valid || !out_stall;
  assign c_free = !c_valid || d_free;
  assign take_c = b_valid && c_free;

  always_comb begin
    cnt_inc            = hold_counter + 19'd1;
    hold_counter_next  = hold_counter;
    held_value_next    = held_value;
    pink_slow_acc_next = pink_slow_acc;
    pink_mid_acc_next  = pink_mid_acc;
    pink_fast_acc_next = pink_fast_acc;
    c_y_next           = b_item.w_val;
    unique case (cfg.mode)
      nms_pkg::MODE_WHITE: begin
        c_y_next = b_item.w_val;
      end
      nms_pkg::MODE_HOLD: begin
        if (cnt_inc > cfg.hold_period) begin
          hold_counter_next = '0;
          held_value_next   = b_item.hold_val;
        end else begin
          hold_counter_next = cnt_inc;
        end
        c_y_next = held_value_next;
      end
      nms_pkg::MODE_PINK: begin
        pink_slow_acc_next = nms_pkg::pole_step(pink_slow_acc, nms_pkg::C_SLOW_POLE,
                                                b_item.slow_term);
        pink_mid_acc_next  = nms_pkg::pole_step(pink_mid_acc, nms_pkg::C_MID_POLE,
                                                b_item.mid_term);
        pink_fast_acc_next = nms_pkg::pole_step(pink_fast_acc, nms_pkg::C_FAST_POLE,
                                                b_item.fast_term);
      end
      nms_pkg::MODE_PULSE: begin
        c_y_next = b_item.pulse_val;
      end
    endcase
  end

  // Pole states already hold the values left by the item in the state stage
  always_comb begin
    pink_sum = 36'(pink_slow_acc) + 36'(pink_mid_acc) + 36'(pink_fast_acc)
             + 36'(c_direct) + 36'sd128;
    pink_y   = nms_pkg::sat_out(pink_sum[35:8]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid       <= 1'b0;
      out_valid     <= 1'b0;
      hold_counter  <= '0;
      held_value    <= '0;
      pink_slow_acc <= '0;
      pink_mid_acc  <= '0;
      pink_fast_acc <= '0;
    end else begin
      if (c_free) begin
        c_valid <= b_valid;
      end
      if (d_free) begin
        out_valid <= c_valid;
      end
      if (take_c) begin
        hold_counter  <= hold_counter_next;
        held_value    <= held_value_next;
        pink_slow_acc <= pink_slow_acc_next;
        pink_mid_acc  <= pink_mid_acc_next;
        pink_fast_acc <= pink_fast_acc_next;
      end
    end
    if (take_c) begin
      c_pink   <= (cfg.mode == nms_pkg::MODE_PINK);
      c_y      <= c_y_next;
      c_direct <= b_item.direct;
    end
    if (d_free && c_valid) begin
      sample_out <= c_pink ? pink_y : c_y;
    end
  end

endmodule

// ===== hw/rtl/multi_mode_noise_shaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mode_noise_shaper
// Four-mode noise generator: white, sample-and-hold, pink, pulse train.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / random_word) takes one uniform
//   random word per audio sample. Output channel (out_valid / out_stall /
//   sample_out) returns one signed Q6.16 sample for every item, in order.
//   Mode, hold period, level and pulse threshold are set over the APB port
//   while no item is in flight.
// Timing:
//   Four register stages (input, product, state, output). One item per cycle
//   sustained while out_stall stays low; the filter poles close their
//   feedback in the state stage, one multiply-add per pole per item.
// Reset:
//   Registers return to their defaults (white mode, hold period 25100,
//   level 0.5, threshold 1.0); counter, held value and pole states clear.
// Backpressure:
//   While out_stall holds a result, the earlier stages keep filling; in_stall
//   rises only once all four stages hold items.
// ----------------------------------------------------------------------------
module multi_mode_noise_shaper (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [nms_pkg::RANDOM_BITS-1:0]    random_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [nms_pkg::OUT_W-1:0]   sample_out,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nms_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  nms_pkg::cfg_t  cfg;
  nms_pkg::item_t b_item;
  logic           b_valid;
  logic           c_free;

  nms_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nms_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .random_word (random_word),
    .cfg         (cfg),
    .b_valid     (b_valid),
    .b_item      (b_item),
    .c_free      (c_free)
  );

  nms_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .b_valid    (b_valid),
    .b_item     (b_item),
    .c_free     (c_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out)
  );

  // Input backs up only behind a held result
  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // A free output side drains the whole pipe
  a_no_stall_when_draining: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // Pipeline empties on reset
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!out_valid && !b_valid))
    else $error("pipeline not empty after reset");

endmodule

// ===== verif/tb_multi_mode_noise_shaper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_mode_noise_shaper
// Self-checking bench for the four-mode noise shaper. Random words stream in
// with random gaps and output stalls. A bit-exact software copy of the white,
// hold, pink and pulse paths predicts every sample. Registers are set and
// read back over APB between bursts.
// ----------------------------------------------------------------------------
module tb_multi_mode_noise_shaper;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1550;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [nms_pkg::RANDOM_BITS-1:0] random_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [nms_pkg::OUT_W-1:0] sample_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [nms_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor copy of registers and state
  nms_pkg::mode_t cur_mode;
  logic [18:0] cur_period;
  logic [16:0] cur_level;
  logic [17:0] cur_thresh;
  logic [18:0] hold_cnt;
  logic signed [nms_pkg::OUT_W-1:0] held_sample;
  int slow_acc;
  int mid_acc;
  int fast_acc;

  logic signed [nms_pkg::OUT_W-1:0] sample_q[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit quiet = 1'b0;  // no gaps and no stalls while set

  multi_mode_noise_shaper u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .random_word (random_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_out  (sample_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 27);
  end

  // ---------------- predictor ----------------
  function automatic longint round_shr(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [nms_pkg::OUT_W-1:0] clamp_out(input longint v);
    if (v > 64'sd4194303) begin
      return nms_pkg::OUT_MAX;
    end else if (v < -64'sd4194304) begin
      return nms_pkg::OUT_MIN;
    end
    return v[nms_pkg::OUT_W-1:0];
  endfunction

  function automatic int pole_next(input int acc, input longint a, input longint b,
                                   input longint w);
    longint v;
    v = round_shr(a * longint'(acc) + b * w * 256, 24);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return int'(v);
  endfunction

  function automatic logic signed [nms_pkg::OUT_W-1:0] next_sample(
    input logic [nms_pkg::RANDOM_BITS-1:0] r
  );
    longint wpos;
    longint w;
    longint y;
    longint sum;
    wpos = longint'(r) * 2;
    w = wpos - 65536;
    case (cur_mode)
      nms_pkg::MODE_WHITE: begin
        y = w;
      end
      nms_pkg::MODE_HOLD: begin
        hold_cnt = hold_cnt + 19'd1;
        if (hold_cnt > cur_period) begin
          hold_cnt = '0;
          held_sample = clamp_out(((longint'(cur_level) * wpos) >>> 16) - 65536);
        end
        y = held_sample;
      end
      nms_pkg::MODE_PINK: begin
        slow_acc = pole_next(slow_acc, nms_pkg::C_SLOW_POLE, nms_pkg::C_SLOW_IN, w);
        mid_acc = pole_next(mid_acc, nms_pkg::C_MID_POLE, nms_pkg::C_MID_IN, w);
        fast_acc = pole_next(fast_acc, nms_pkg::C_FAST_POLE, nms_pkg::C_FAST_IN, w);
        sum = longint'(slow_acc) + longint'(mid_acc) + longint'(fast_acc);
        sum += round_shr(longint'(nms_pkg::C_DIRECT) * w * 256, 24);
        y = round_shr(sum, 8);
      end
      default: begin
        y = (wpos > longint'(cur_thresh)) ? longint'(cur_level) : -longint'(cur_level);
      end
    endcase
    return clamp_out(y);
  endfunction

  function automatic logic [31:0] reg_value(input nms_pkg::reg_idx_t idx);
    case (idx)
      nms_pkg::REG_MODE:        return 32'(cur_mode);
      nms_pkg::REG_HOLD_PERIOD: return 32'(cur_period);
      nms_pkg::REG_OUT_LEVEL:   return 32'(cur_level);
      default:                  return 32'(cur_thresh);
    endcase
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    logic signed [nms_pkg::OUT_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (sample_q.size() == 0) begin
        $error("sample_out: no sample expected, got %0d", sample_out);
        mismatch_count++;
      end else begin
        want = sample_q.pop_front();
        if (sample_out !== want) begin
          $error("sample_out: expected %0d, got %0d", want, sample_out);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------- drivers ----------------
  task automatic send_word(input logic [nms_pkg::RANDOM_BITS-1:0] r);
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    random_word <= r;
    do @(posedge clk); while (in_stall);
    sample_q.push_back(next_sample(r));
  endtask

  // wait for the pipe to empty so registers can change
  task automatic drain();
    in_valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic check_reg(input nms_pkg::reg_idx_t idx);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== reg_value(idx)) begin
      $error("prdata[%0d]: expected %0h, got %0h", idx, reg_value(idx), got);
      mismatch_count++;
    end
  endtask

  task automatic set_reg(input nms_pkg::reg_idx_t idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      nms_pkg::REG_MODE:        cur_mode = nms_pkg::mode_t'(data[1:0]);
      nms_pkg::REG_HOLD_PERIOD: cur_period = data[18:0];
      nms_pkg::REG_OUT_LEVEL:   cur_level = data[16:0];
      default:                  cur_thresh = data[17:0];
    endcase
    check_reg(idx);
  endtask

  // sometimes set junk above the register width
  function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
    if ($urandom_range(3) == 0) begin
      return v | ($urandom() << w);
    end
    return v;
  endfunction

  function automatic logic [nms_pkg::RANDOM_BITS-1:0] pick_word(input int bias);
    int p;
    p = $urandom_range(99);
    if (bias == 1) begin
      return (p < 20) ? 16'hFFFF : 16'($urandom_range(60000, 65535));
    end else if (bias == 2) begin
      return (p < 20) ? 16'h0000 : 16'($urandom_range(0, 5535));
    end
    if (p < 8) begin
      return 16'h0000;
    end else if (p < 16) begin
      return 16'hFFFF;
    end
    return 16'($urandom_range(65535));
  endfunction

  // ---------------- tests ----------------
  task automatic test_reset_state();
    check_reg(nms_pkg::REG_MODE);
    check_reg(nms_pkg::REG_HOLD_PERIOD);
    check_reg(nms_pkg::REG_OUT_LEVEL);
    check_reg(nms_pkg::REG_PULSE_THRESHOLD);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h8000);
    send_word(16'h5555);
    send_word(16'hAAAA);
    drain();
  endtask

  task automatic test_hold();
    set_reg(nms_pkg::REG_MODE, 32'(nms_pkg::MODE_HOLD));
    // period zero refreshes every item
    set_reg(nms_pkg::REG_HOLD_PERIOD, 32'd0);
    set_reg(nms_pkg::REG_OUT_LEVEL, 32'd65536);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'd12345);
    drain();
    set_reg(nms_pkg::REG_HOLD_PERIOD, 32'd2);
    send_word(16'd1000);
    send_word(16'd2000);
    send_word(16'd3000);
    drain();
    // level above one; upper bits of the write must drop
    set_reg(nms_pkg::REG_OUT_LEVEL, 32'hFFFF_FFFF);
    set_reg(nms_pkg::REG_HOLD_PERIOD, 32'd0);
    send_word(16'hFFFF);
    send_word(16'h0001);
    drain();
    // max period: held value frozen
    set_reg(nms_pkg::REG_HOLD_PERIOD, 32'hFFFF_FFFF);
    send_word(16'h1234);
    send_word(16'hFEDC);
    drain();
  endtask

  task automatic test_pulse();
    set_reg(nms_pkg::REG_MODE, 32'(nms_pkg::MODE_PULSE));
    set_reg(nms_pkg::REG_OUT_LEVEL, 32'd65536);
    set_reg(nms_pkg::REG_PULSE_THRESHOLD, 32'd0);
    send_word(16'h0000);
    send_word(16'h0001);
    drain();
    set_reg(nms_pkg::REG_PULSE_THRESHOLD, 32'd131072);
    send_word(16'hFFFF);
    drain();
    set_reg(nms_pkg::REG_PULSE_THRESHOLD, 32'd131069);
    set_reg(nms_pkg::REG_OUT_LEVEL, 32'd131071);
    send_word(16'hFFFF);
    send_word(16'hFFFE);
    drain();
    set_reg(nms_pkg::REG_OUT_LEVEL, 32'd0);
    send_word(16'hFFFF);
    drain();
  endtask

  task automatic test_pink_short();
    set_reg(nms_pkg::REG_MODE, 32'(nms_pkg::MODE_PINK));
    send_word(16'hFFFF);
    send_word(16'h0000);
    send_word(16'h8000);
    send_word(16'hFFFF);
    drain();
  endtask

  // long one-sided runs push the slow pole toward its limits
  task automatic test_pink_drive();
    set_reg(nms_pkg::REG_MODE, 32'(nms_pkg::MODE_PINK));
    quiet = 1'b1;
    repeat (400) send_word(pick_word(1));
    quiet = 1'b0;
    repeat (400) send_word(pick_word(2));
    repeat (50) send_word(pick_word(0));
    drain();
  endtask

  task automatic test_random_mix();
    int left;
    int n;
    int bias;
    int p;
    logic [31:0] v;
    left = RANDOM_ITEMS - 925;
    while (left > 0) begin
      set_reg(nms_pkg::REG_MODE, with_junk(32'($urandom_range(3)), 2));
      p = $urandom_range(9);
      v = (p == 0) ? 32'd0 : (p == 1) ? 32'd524287 :
          (p == 2) ? 32'($urandom_range(524287)) : 32'($urandom_range(1, 12));
      set_reg(nms_pkg::REG_HOLD_PERIOD, with_junk(v, 19));
      p = $urandom_range(9);
      v = (p == 0) ? 32'd0 : (p == 1) ? 32'd65536 :
          (p == 2) ? 32'd131071 : 32'($urandom_range(131071));
      set_reg(nms_pkg::REG_OUT_LEVEL, with_junk(v, 17));
      p = $urandom_range(9);
      v = (p == 0) ? 32'd0 : (p == 1) ? 32'd131072 :
          (p == 2) ? 32'd262143 : 32'($urandom_range(131072));
      set_reg(nms_pkg::REG_PULSE_THRESHOLD, with_junk(v, 18));
      bias = (cur_mode == nms_pkg::MODE_PINK) ? $urandom_range(2) : 0;
      n = $urandom_range(20, 120);
      repeat (n) send_word(pick_word(bias));
      left -= n;
      drain();
    end
  endtask

  initial begin
    cur_mode = nms_pkg::MODE_WHITE;
    cur_period = nms_pkg::HOLD_PERIOD_RST;
    cur_level = nms_pkg::OUT_LEVEL_RST;
    cur_thresh = nms_pkg::PULSE_THRESHOLD_RST;
    hold_cnt = '0;
    held_sample = '0;
    slow_acc = 0;
    mid_acc = 0;
    fast_acc = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_hold();
    test_pulse();
    test_pink_short();
    test_pink_drive();
    test_random_mix();
    drain();
    if (mismatch_count == 0 && sample_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== multi_mode_noise_shaper.f =====
hw/rtl/nms_pkg.sv
hw/rtl/nms_regs.sv
hw/rtl/nms_front.sv
hw/rtl/nms_core.sv
hw/rtl/multi_mode_noise_shaper.sv
verif/tb_multi_mode_noise_shaper.sv
